FILE: sv/assert_macros.svh
// Assertion macros used by the walk sequencer of the page table walker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is checked only while the reset is released.
`define STPW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion that is checked at every clock edge, reset included.
`define STPW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/stpw_pkg.sv
// Package with the types, codes and constants of the Sv39 page table walker.
`timescale 1ns / 1ps
package stpw_pkg;

  localparam int STORE_PAGES_DEF  = 8;
  localparam int ENTRIES_PER_PAGE = 512;
  localparam int LEVEL_BITS       = 9;
  localparam int PAGE_SHIFT       = 12;

  localparam int VA_W    = 39;
  localparam int SLOT_W  = 12;
  localparam int PTE_W   = 64;
  localparam int PPN_W   = 44;
  localparam int PA_W    = 56;
  localparam int LVL_W   = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [LVL_W-1:0] TOP_LEVEL = 2'd2;

  localparam int PTE_V   = 0;
  localparam int PTE_R   = 1;
  localparam int PTE_W_B = 2;
  localparam int PTE_X   = 3;
  localparam int PTE_U   = 4;
  localparam int PPN_LSB = 10;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_XLATE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROOT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_HIGH     = 3'd1,
    ST_UNMAPPED = 3'd2,
    ST_NOT_USER = 3'd3,
    ST_OUTSIDE  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [PPN_W-1:0] root;
    logic [PPN_W-1:0] base;
  } cfg_t;

  typedef struct packed {
    logic [PA_W-1:0]  phys_addr;
    status_e          status;
    logic [LVL_W-1:0] leaf_level;
  } res_t;

endpackage

FILE: sv/stpw_req_if.sv
// Interface of the input item channel of the page table walker.
`timescale 1ns / 1ps
interface stpw_req_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [stpw_pkg::VA_W-1:0]   virt_addr;
  logic [stpw_pkg::SLOT_W-1:0] entry_slot;
  logic [stpw_pkg::PTE_W-1:0]  entry_word;

  modport source (output valid, mode, virt_addr, entry_slot, entry_word, input ready);
  modport sink (input valid, mode, virt_addr, entry_slot, entry_word, output ready);
endinterface

FILE: sv/stpw_rsp_if.sv
// Interface of the result channel of the page table walker.
`timescale 1ns / 1ps
interface stpw_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [stpw_pkg::PA_W-1:0]  phys_addr;
  logic [2:0]                 status;
  logic [stpw_pkg::LVL_W-1:0] leaf_level;

  modport source (output valid, phys_addr, status, leaf_level, input ready);
  modport sink (input valid, phys_addr, status, leaf_level, output ready);
endinterface

FILE: sv/stpw_cfg_if.sv
// Interface of the configuration write channel of the page table walker.
`timescale 1ns / 1ps
interface stpw_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [stpw_pkg::CFG_IDX_W-1:0] index;
  logic [stpw_pkg::PPN_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/sv39_page_table_walker.sv
// Top level of the Sv39 page table walker.
// The req channel takes items: mode 0 writes entry_word into the table store
// at entry_slot (slots beyond the store are dropped), mode 1 translates
// virt_addr through up to three levels of tables held in the store.
// Every item gives exactly one transaction on the rsp channel: physical
// address, status and leaf level, all zero for a write.
// The cfg channel is always ready and sets the root table page (index 0) and
// the physical page held in the first store page (index 1); other indexes
// are ignored. Write it only while the block is idle.
// A write finishes in the cycle of acceptance and its result is registered;
// the block is idle again at once when the output register is free. A
// translation reads one table entry per cycle from the single store port;
// an address that is too high or a root page outside the store finishes in
// the cycle of acceptance. No new item is taken until the current one ends.
// After reset the store is swept to zero, one entry per cycle, over all
// STORE_PAGES * 512 entries (4096 by default); req is not ready meanwhile.
// The result waits in an output register while rsp is stalled; one more
// item can be taken and finished into a holding register behind it.
`timescale 1ns / 1ps
module sv39_page_table_walker #(
  parameter int STORE_PAGES = stpw_pkg::STORE_PAGES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  stpw_cfg_if.sink    cfg,
  stpw_req_if.sink    req,
  stpw_rsp_if.source  rsp
);

  stpw_pkg::cfg_t cfg_q, cfg_d;
  stpw_pkg::res_t out_q, fin_res;
  logic           out_valid_q, out_valid_d;
  logic           fin_valid, out_free;

  assign cfg.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg.valid) begin
      unique case (cfg.index)
        stpw_pkg::CFG_ROOT: cfg_d.root = cfg.data;
        stpw_pkg::CFG_BASE: cfg_d.base = cfg.data;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  assign out_free    = !out_valid_q || rsp.ready;
  assign out_valid_d = fin_valid || (out_valid_q && !rsp.ready);

  stpw_ctrl #(
    .STORE_PAGES (STORE_PAGES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req),
    .cfg_i       (cfg_q),
    .out_free_i  (out_free),
    .fin_valid_o (fin_valid),
    .fin_res_o   (fin_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_valid) begin
      out_q <= fin_res;
    end
  end

  assign rsp.valid      = out_valid_q;
  assign rsp.phys_addr  = out_q.phys_addr;
  assign rsp.status     = out_q.status;
  assign rsp.leaf_level = out_q.leaf_level;

endmodule

FILE: sv/stpw_ram.sv
// Generic single-port synchronous RAM with a registered read.
`timescale 1ns / 1ps
module stpw_ram #(
  parameter int  WIDTH = 64,
  parameter int  DEPTH = 4096,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/stpw_ctrl.sv
// Walk sequencer: clears the table store, loads entries and walks the tables.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stpw_ctrl #(
  parameter int STORE_PAGES = stpw_pkg::STORE_PAGES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  stpw_req_if.sink        req,
  input  stpw_pkg::cfg_t  cfg_i,
  input  logic            out_free_i,
  output logic            fin_valid_o,
  output stpw_pkg::res_t  fin_res_o
);

  localparam int STORE_DEPTH = STORE_PAGES * stpw_pkg::ENTRIES_PER_PAGE;
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int PW = (STORE_PAGES > 1) ? $clog2(STORE_PAGES) : 1;

  stpw_pkg::state_e state_q, state_d;
  logic [AW-1:0]                clr_q, clr_d;
  logic [stpw_pkg::LVL_W-1:0]   lvl_q, lvl_d;
  logic [stpw_pkg::VA_W-1:0]    va_q, va_d;
  stpw_pkg::res_t               res_q, res_d;

  logic                         ram_we, ram_re;
  logic [AW-1:0]                ram_addr;
  logic [stpw_pkg::PTE_W-1:0]   ram_wdata, pte;

  logic [stpw_pkg::PPN_W-1:0]   pg_sel, pg_diff;
  logic                         pg_out;
  logic [stpw_pkg::VA_W-1:0]    va_cur;
  logic [stpw_pkg::LVL_W-1:0]   lvl_rd;
  logic [stpw_pkg::LEVEL_BITS-1:0] idx;
  logic [AW-1:0]                rd_addr, wr_addr;
  logic [31:0]                  slot_ext;
  logic                         slot_ok;
  logic [stpw_pkg::PA_W-1:0]    frame, off;
  logic                         done;
  stpw_pkg::res_t               done_res;

  stpw_ram #(
    .WIDTH (stpw_pkg::PTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (pte)
  );

  // One range check serves the root page at accept and each next table page.
  assign pg_sel  = (state_q == stpw_pkg::S_IDLE) ? cfg_i.root
                 : pte[stpw_pkg::PPN_LSB +: stpw_pkg::PPN_W];
  assign pg_diff = pg_sel - cfg_i.base;
  assign pg_out  = (pg_sel < cfg_i.base) ||
                   (pg_diff >= stpw_pkg::PPN_W'(STORE_PAGES));

  assign va_cur = (state_q == stpw_pkg::S_IDLE) ? req.virt_addr : va_q;
  assign lvl_rd = (state_q == stpw_pkg::S_IDLE) ? stpw_pkg::TOP_LEVEL : lvl_q - 2'd1;

  always_comb begin
    case (lvl_rd)
      2'd2:    idx = va_cur[38:30];
      2'd1:    idx = va_cur[29:21];
      default: idx = va_cur[20:12];
    endcase
  end

  assign rd_addr  = AW'({pg_diff[PW-1:0], idx});
  assign slot_ext = 32'(req.entry_slot);
  assign slot_ok  = slot_ext < 32'(STORE_DEPTH);
  assign wr_addr  = AW'(slot_ext);

  assign frame = {pte[stpw_pkg::PPN_LSB +: stpw_pkg::PPN_W],
                  {stpw_pkg::PAGE_SHIFT{1'b0}}};

  always_comb begin
    case (lvl_q)
      2'd2:    off = stpw_pkg::PA_W'(va_q[29:0]);
      2'd1:    off = stpw_pkg::PA_W'(va_q[20:0]);
      default: off = stpw_pkg::PA_W'(va_q[11:0]);
    endcase
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    lvl_d     = lvl_q;
    va_d      = va_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = rd_addr;
    ram_wdata = req.entry_word;
    req.ready = 1'b0;
    fin_valid_o = 1'b0;
    fin_res_o   = res_q;
    done      = 1'b0;
    done_res  = '{phys_addr: '0, status: stpw_pkg::ST_OK, leaf_level: '0};

    unique case (state_q)
      stpw_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(STORE_DEPTH - 1)) begin
          state_d = stpw_pkg::S_IDLE;
        end
      end
      stpw_pkg::S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          if (req.mode == stpw_pkg::MODE_WRITE) begin
            ram_we   = slot_ok;
            ram_addr = wr_addr;
            done     = 1'b1;
          end else if (req.virt_addr[stpw_pkg::VA_W-1]) begin
            done            = 1'b1;
            done_res.status = stpw_pkg::ST_HIGH;
          end else if (pg_out) begin
            done            = 1'b1;
            done_res.status = stpw_pkg::ST_OUTSIDE;
          end else begin
            ram_re  = 1'b1;
            va_d    = req.virt_addr;
            lvl_d   = stpw_pkg::TOP_LEVEL;
            state_d = stpw_pkg::S_CHECK;
          end
        end
      end
      stpw_pkg::S_CHECK: begin
        if (!pte[stpw_pkg::PTE_V]) begin
          done            = 1'b1;
          done_res.status = stpw_pkg::ST_UNMAPPED;
        end else if (pte[stpw_pkg::PTE_R] || pte[stpw_pkg::PTE_W_B] ||
                     pte[stpw_pkg::PTE_X] || (lvl_q == 2'd0)) begin
          done = 1'b1;
          if (!pte[stpw_pkg::PTE_U]) begin
            done_res.status = stpw_pkg::ST_NOT_USER;
          end else begin
            done_res.phys_addr  = frame + off;
            done_res.leaf_level = lvl_q;
          end
        end else if (pg_out) begin
          done            = 1'b1;
          done_res.status = stpw_pkg::ST_OUTSIDE;
        end else begin
          ram_re = 1'b1;
          lvl_d  = lvl_rd;
        end
      end
      stpw_pkg::S_DONE: begin
        if (out_free_i) begin
          fin_valid_o = 1'b1;
          state_d     = stpw_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = stpw_pkg::S_CLEAR;
      end
    endcase

    if (done) begin
      if (out_free_i) begin
        fin_valid_o = 1'b1;
        fin_res_o   = done_res;
        state_d     = stpw_pkg::S_IDLE;
      end else begin
        res_d   = done_res;
        state_d = stpw_pkg::S_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stpw_pkg::S_CLEAR;
      clr_q   <= '0;
      lvl_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      lvl_q   <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    va_q  <= va_d;
    res_q <= res_d;
  end

  `STPW_ASSERT(a_fin_needs_room, clk_i, rst_ni, fin_valid_o |-> out_free_i, "result lost")
  `STPW_ASSERT(a_read_then_check, clk_i, rst_ni, ram_re |=> (state_q == stpw_pkg::S_CHECK), "read not checked")
  `STPW_ASSERT(a_no_write_in_walk, clk_i, rst_ni, (state_q == stpw_pkg::S_CHECK) |-> !ram_we, "store written during walk")

endmodule
